/* design/fatlb_pkg.sv */
// Shared types and constants for the fully associative translation buffer.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
package fatlb_pkg;

    // Default sizing, handed to the top level parameters
    localparam int INDEX_BITS_DEF = 4;
    localparam int PFN_BITS_DEF   = 8;

    // Fixed field widths of the stream payload
    localparam int MODE_W = 2;
    localparam int VPN_W  = 8;
    localparam int RW_W   = 2;
    localparam int FPN_W  = 8;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 16;

    // Operation codes carried on the input tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP     = 2'd0,
        MODE_INSERT     = 2'd1,
        MODE_INVALIDATE = 2'd2,
        MODE_FLUSH      = 2'd3
    } t_mode;

    // Permission codes
    localparam logic [RW_W-1:0] RW_WRITE = 2'd2;
    localparam logic [RW_W-1:0] RW_RDWR  = 2'd3;

    // Controller states
    typedef enum logic {
        ST_ACCEPT = 1'b0,
        ST_EXEC   = 1'b1
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

/* design/fatlb_ctrl.sv */
// Controller for the translation buffer: sequences capture and execute
// beats and owns the output valid flag. Depends on fatlb_pkg.
module fatlb_ctrl import fatlb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   exec_go;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        accept      = 1'b0;
        exec_go     = 1'b0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_ACCEPT: begin
                accept = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    exec_go     = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_ACCEPT;
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

    assign o_s_tready      = (r_state == ST_ACCEPT);
    assign o_m_tvalid      = r_out_valid;
    assign o_cmd.capture   = accept;
    assign o_cmd.execute   = exec_go;

endmodule

/* design/fatlb_dp.sv */
// Datapath for the translation buffer: entry cells, parallel compare,
// priority select, update and the result register. Depends on fatlb_pkg.
module fatlb_dp import fatlb_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int PFN_BITS   = PFN_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [VPN_W-1:0] i_vpn,
    input  logic [RW_W-1:0]  i_rw,
    input  logic [FPN_W-1:0] i_fill_pfn,
    output logic             o_hit,
    output logic [FPN_W-1:0] o_found_pfn,
    output logic             o_dropped
);

    localparam int NUM_ENTRIES = 1 << INDEX_BITS;

    // Entry cells
    logic [NUM_ENTRIES-1:0] r_valid, n_valid;
    logic [VPN_W-1:0]       r_vpn  [NUM_ENTRIES];
    logic [RW_W-1:0]        r_perm [NUM_ENTRIES];
    logic [PFN_BITS-1:0]    r_pfn  [NUM_ENTRIES];

    // Captured item and match vectors
    t_mode                  r_mode;
    logic [VPN_W-1:0]       r_req_vpn;
    logic [RW_W-1:0]        r_req_rw;
    logic [PFN_BITS-1:0]    r_req_pfn;
    logic [NUM_ENTRIES-1:0] r_lk_match;
    logic [NUM_ENTRIES-1:0] r_vpn_match;

    // Result register
    logic             r_hit;
    logic [FPN_W-1:0] r_found;
    logic             r_dropped;

    logic [RW_W-1:0]        want;
    logic [NUM_ENTRIES-1:0] lk_match, vpn_match;
    logic [PFN_BITS-1:0]    fill_w;
    logic [NUM_ENTRIES-1:0] free_vec, lk_1h, upd_1h, free_1h, ins_1h;
    logic                   any_vpn, any_free;
    logic [PFN_BITS-1:0]    sel_pfn;
    logic [FPN_W-1:0]       sel_fpn;

    // Fit the fill frame to the stored width
    generate
        if (PFN_BITS > FPN_W) begin : g_wide
            assign fill_w  = {{(PFN_BITS-FPN_W){1'b0}}, i_fill_pfn};
            assign sel_fpn = sel_pfn[FPN_W-1:0];
        end else if (PFN_BITS == FPN_W) begin : g_same
            assign fill_w  = i_fill_pfn;
            assign sel_fpn = sel_pfn;
        end else begin : g_narrow
            assign fill_w  = i_fill_pfn[PFN_BITS-1:0];
            assign sel_fpn = {{(FPN_W-PFN_BITS){1'b0}}, sel_pfn};
        end
    endgenerate

    // Compare the incoming item against every entry
    assign want = (i_rw == RW_WRITE) ? RW_RDWR : i_rw;
    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            vpn_match[i] = r_valid[i] && (r_vpn[i] == i_vpn);
            lk_match[i]  = vpn_match[i] && (r_perm[i] == want);
        end
    end

    // Capture the item and its match vectors
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode      <= t_mode'(i_mode);
            r_req_vpn   <= i_vpn;
            r_req_rw    <= i_rw;
            r_req_pfn   <= fill_w;
            r_lk_match  <= lk_match;
            r_vpn_match <= vpn_match;
        end
    end

    // Pick the lowest-index candidates
    assign free_vec = ~r_valid;
    assign lk_1h    = r_lk_match & (~r_lk_match + NUM_ENTRIES'(1));
    assign upd_1h   = r_vpn_match & (~r_vpn_match + NUM_ENTRIES'(1));
    assign free_1h  = free_vec & (~free_vec + NUM_ENTRIES'(1));
    assign any_vpn  = |r_vpn_match;
    assign any_free = |free_vec;
    assign ins_1h   = any_vpn ? upd_1h : free_1h;

    // Select the frame of the hit entry
    always_comb begin
        sel_pfn = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            sel_pfn = sel_pfn | (lk_1h[i] ? r_pfn[i] : '0);
        end
    end

    // Next valid bits
    always_comb begin
        n_valid = r_valid;
        if (i_cmd.execute) begin
            unique case (r_mode)
                MODE_INSERT:     n_valid = r_valid | ins_1h;
                MODE_INVALIDATE: n_valid = r_valid & ~r_vpn_match;
                MODE_FLUSH:      n_valid = '0;
                default:         n_valid = r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Write entry payload on insert or update
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && (r_mode == MODE_INSERT)) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (ins_1h[i]) begin
                    r_vpn[i]  <= r_req_vpn;
                    r_perm[i] <= r_req_rw;
                    r_pfn[i]  <= r_req_pfn;
                end
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_hit     <= (r_mode == MODE_LOOKUP) && (|r_lk_match);
            r_found   <= (r_mode == MODE_LOOKUP) ? sel_fpn : '0;
            r_dropped <= (r_mode == MODE_INSERT) && !any_vpn && !any_free;
        end
    end

    assign o_hit       = r_hit;
    assign o_found_pfn = r_found;
    assign o_dropped   = r_dropped;

endmodule

/* design/fully_associative_tlb.sv */
// A beat is captured together with its parallel compare results; the
// execute step then does priority select and loads the result register
// for the master side. The input takes no new beat while an item is in
// execute, and a stalled result holds execution of the next item.
// Reset (synchronous, active low) clears all valid bits at once and empties
// the output; the block is ready for a beat as soon as reset is released.
module fully_associative_tlb import fatlb_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int PFN_BITS   = PFN_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // vpn[7:0], rw[9:8], fill_pfn[17:10], zero[23:18]
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // mode[1:0]
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // hit[0], found_pfn[8:1], dropped[9], zero[15:10]
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    t_cmd             cmd;
    logic             hit;
    logic             dropped;
    logic [FPN_W-1:0] found_pfn;

    fatlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    fatlb_dp #(
        .INDEX_BITS (INDEX_BITS),
        .PFN_BITS   (PFN_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (i_s_tuser),
        .i_vpn       (i_s_tdata[7:0]),
        .i_rw        (i_s_tdata[9:8]),
        .i_fill_pfn  (i_s_tdata[17:10]),
        .o_hit       (hit),
        .o_found_pfn (found_pfn),
        .o_dropped   (dropped)
    );

    // Pack the result beat
    assign o_m_tdata = {6'b0, dropped, found_pfn, hit};

endmodule

/* design/fatlb_checker.sv */
// Port-level checks for the translation buffer, bound to the top level.
// Depends on fatlb_pkg for the payload widths.
module fatlb_checker import fatlb_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    // An accepted beat blocks the input while its item is in execute
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after an accepted beat");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // Hit and dropped never come together
    a_hit_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[9]))
        else $error("hit and dropped both set");

    // A miss carries a zero frame
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[8:1] == 8'd0))
        else $error("frame nonzero without hit");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind fully_associative_tlb fatlb_checker u_fatlb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
